// ===== src/gtg_pkg.sv =====
// shared types, constants and tables of the go-to-goal steering block
package gtg_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 16;

   // datapath widths
   localparam int unsigned XW       = 58;   // cordic x and y
   localparam int unsigned ZW       = 36;   // cordic angle, q6.30
   localparam int unsigned PRESHIFT = 20;
   localparam int unsigned MW       = XW - PRESHIFT; // magnitude after pre-shift removal
   localparam int unsigned DW       = 38;   // distance, q22.16
   localparam int unsigned EW       = 20;   // heading error, q7.13

   localparam logic signed [ZW-1:0] PI_Q30     = 36'sd3373259426;
   localparam logic signed [ZW:0]   TWO_PI_Q30 = 37'sd6746518852;
   localparam logic [29:0]          INV_K_Q30  = 30'd652032874;

   // register reset values
   localparam logic [16:0] DIST_TOL_RST  = 17'd6554;
   localparam logic [14:0] ANGLE_TOL_RST = 15'd410;
   localparam logic [14:0] MAX_LIN_RST   = 15'd4096;
   localparam logic [14:0] MAX_ANG_RST   = 15'd8192;
   localparam logic [14:0] TURN_GAIN_RST = 15'd16384;
   localparam logic [14:0] DRIVE_GAIN_RST = 15'd4096;
   localparam logic [14:0] HEAD_GAIN_RST = 15'd8192;

   typedef enum logic [2:0] {
      CSR_DIST_TOL   = 3'd0,
      CSR_ANGLE_TOL  = 3'd1,
      CSR_MAX_LIN    = 3'd2,
      CSR_MAX_ANG    = 3'd3,
      CSR_TURN_GAIN  = 3'd4,
      CSR_DRIVE_GAIN = 3'd5,
      CSR_HEAD_GAIN  = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_SET_GOAL = 1'b0,
      OP_TICK     = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_YAW_INIT,
      ST_YAW_ITER,
      ST_TGT_INIT,
      ST_TGT_ITER,
      ST_DIST_LO,
      ST_DIST_HI,
      ST_ERR,
      ST_GAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic prod;
      logic yaw_init;
      logic tgt_init;
      logic step;
      logic dist_lo;
      logic dist_hi;
      logic err;
      logic gain;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic goal_active;
      logic prod_last;
      logic iter_last;
   } status_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = 36'sd843314857;
         5'd1:  v = 36'sd497837829;
         5'd2:  v = 36'sd263043837;
         5'd3:  v = 36'sd133525159;
         5'd4:  v = 36'sd67021687;
         5'd5:  v = 36'sd33543516;
         5'd6:  v = 36'sd16775851;
         5'd7:  v = 36'sd8388437;
         5'd8:  v = 36'sd4194283;
         5'd9:  v = 36'sd2097149;
         5'd31: v = '0;
         default: v = ZW'(64'sd1 <<< (30 - idx));
      endcase
      return v;
   endfunction

endpackage

// ===== src/gtg_ctrl.sv =====
// controller state machine sequencing the steering datapath
module gtg_ctrl
   import gtg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_opcode == OP_TICK && status.goal_active) begin
                  state_in = ST_PROD;
               end
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            if (status.prod_last) begin
               state_in = ST_YAW_INIT;
            end
         end
         ST_YAW_INIT: begin
            cmd.yaw_init = 1'b1;
            state_in     = ST_YAW_ITER;
         end
         ST_YAW_ITER: begin
            cmd.step = 1'b1;
            if (status.iter_last) begin
               state_in = ST_TGT_INIT;
            end
         end
         ST_TGT_INIT: begin
            cmd.tgt_init = 1'b1;
            state_in     = ST_TGT_ITER;
         end
         ST_TGT_ITER: begin
            cmd.step = 1'b1;
            if (status.iter_last) begin
               state_in = ST_DIST_LO;
            end
         end
         ST_DIST_LO: begin
            cmd.dist_lo = 1'b1;
            state_in    = ST_DIST_HI;
         end
         ST_DIST_HI: begin
            cmd.dist_hi = 1'b1;
            state_in    = ST_ERR;
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/gtg_datapath.sv =====
// steering datapath: registers, quaternion products, shared cordic, gains
module gtg_datapath
   import gtg_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_wdata,
   input  logic               req_opcode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  cmd_type            cmd,
   output status_type         status,
   output logic [14:0]        rsp_linear_speed,
   output logic signed [15:0] rsp_angular_speed,
   output logic               rsp_goal_reached
);

   localparam int unsigned IW = $clog2(CORDIC_STEPS);
   localparam logic [2:0] PROD_LAST = 3'd7;
   localparam logic [2:0] PR_WW = 3'd0, PR_XX = 3'd1, PR_YY = 3'd2, PR_ZZ = 3'd3;
   localparam logic [2:0] PR_XY = 3'd4, PR_WZ = 3'd5, PR_XZ = 3'd6, PR_WY = 3'd7;
   localparam logic signed [ZW:0] PI_EXT = $signed({PI_Q30[ZW-1], PI_Q30});

   // configuration
   logic [16:0] dist_tol_ff;
   logic [14:0] angle_tol_ff, max_lin_ff, max_ang_ff;
   logic [14:0] turn_gain_ff, drive_gain_ff, head_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_tol_ff   <= DIST_TOL_RST;
         angle_tol_ff  <= ANGLE_TOL_RST;
         max_lin_ff    <= MAX_LIN_RST;
         max_ang_ff    <= MAX_ANG_RST;
         turn_gain_ff  <= TURN_GAIN_RST;
         drive_gain_ff <= DRIVE_GAIN_RST;
         head_gain_ff  <= HEAD_GAIN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DIST_TOL:   dist_tol_ff   <= csr_wdata;
            CSR_ANGLE_TOL:  angle_tol_ff  <= csr_wdata[14:0];
            CSR_MAX_LIN:    max_lin_ff    <= csr_wdata[14:0];
            CSR_MAX_ANG:    max_ang_ff    <= csr_wdata[14:0];
            CSR_TURN_GAIN:  turn_gain_ff  <= csr_wdata[14:0];
            CSR_DRIVE_GAIN: drive_gain_ff <= csr_wdata[14:0];
            CSR_HEAD_GAIN:  head_gain_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // goal state
   logic               goal_active_ff;
   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic               reached_in, reached_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_active_ff <= 1'b0;
      end else if (cmd.capture && req_opcode == OP_SET_GOAL) begin
         goal_active_ff <= 1'b1;
      end else if (cmd.err && reached_in) begin
         goal_active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_opcode == OP_SET_GOAL) begin
         goal_x_ff <= req_pos_x;
         goal_y_ff <= req_pos_y;
      end
   end

   // pose capture
   logic signed [31:0] pos_x_ff, pos_y_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         qx_ff    <= req_quat_x;
         qy_ff    <= req_quat_y;
         qz_ff    <= req_quat_z;
         qw_ff    <= req_quat_w;
      end
   end

   // iteration counter, shared by product and cordic phases
   logic [IW-1:0] iter_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture || cmd.yaw_init || cmd.tgt_init) begin
         iter_ff <= '0;
      end else if (cmd.prod || cmd.step) begin
         iter_ff <= iter_ff + 1'b1;
      end
   end

   // quaternion products, one a cycle
   logic signed [15:0] pa, pb;
   logic signed [31:0] prod;
   logic signed [33:0] prod_ext;
   logic signed [33:0] d_ff, den_ff, num_ff, g_ff;

   always_comb begin
      case (iter_ff[2:0])
         PR_WW:   begin pa = qw_ff; pb = qw_ff; end
         PR_XX:   begin pa = qx_ff; pb = qx_ff; end
         PR_YY:   begin pa = qy_ff; pb = qy_ff; end
         PR_ZZ:   begin pa = qz_ff; pb = qz_ff; end
         PR_XY:   begin pa = qx_ff; pb = qy_ff; end
         PR_WZ:   begin pa = qw_ff; pb = qz_ff; end
         PR_XZ:   begin pa = qx_ff; pb = qz_ff; end
         default: begin pa = qw_ff; pb = qy_ff; end
      endcase
   end

   assign prod     = pa * pb;
   assign prod_ext = 34'(prod);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         d_ff   <= '0;
         den_ff <= '0;
         num_ff <= '0;
         g_ff   <= '0;
      end else if (cmd.prod) begin
         case (iter_ff[2:0])
            PR_WW, PR_XX: begin
               d_ff   <= d_ff + prod_ext;
               den_ff <= den_ff + prod_ext;
            end
            PR_YY, PR_ZZ: begin
               d_ff   <= d_ff + prod_ext;
               den_ff <= den_ff - prod_ext;
            end
            PR_XY, PR_WZ: num_ff <= num_ff + prod_ext;
            PR_XZ:        g_ff   <= g_ff + prod_ext;
            default:      g_ff   <= g_ff - prod_ext;
         endcase
      end
   end

   assign status.prod_last   = (iter_ff[2:0] == PROD_LAST);
   assign status.iter_last   = (iter_ff == IW'(CORDIC_STEPS - 1));
   assign status.goal_active = goal_active_ff;

   // cordic vectoring unit
   logic signed [XW-1:0] x_ff, y_ff, ix, iy;
   logic signed [ZW-1:0] z_ff, yaw_ff;
   logic signed [32:0]   dx, dy;
   logic signed [34:0]   num2;
   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] at;
   logic [33:0]          g_abs;
   logic                 degen;

   assign dx   = {goal_x_ff[31], goal_x_ff} - {pos_x_ff[31], pos_x_ff};
   assign dy   = {goal_y_ff[31], goal_y_ff} - {pos_y_ff[31], pos_y_ff};
   assign num2 = {num_ff, 1'b0};

   always_comb begin
      if (cmd.tgt_init) begin
         ix = {{(XW - 33 - PRESHIFT){dx[32]}}, dx, {PRESHIFT{1'b0}}};
         iy = {{(XW - 33 - PRESHIFT){dy[32]}}, dy, {PRESHIFT{1'b0}}};
      end else begin
         ix = {{(XW - 34 - PRESHIFT){den_ff[33]}}, den_ff, {PRESHIFT{1'b0}}};
         iy = {{(XW - 35 - PRESHIFT){num2[34]}}, num2, {PRESHIFT{1'b0}}};
      end
   end

   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;
   assign at = atan_q30(5'(iter_ff));

   // pitch at a right angle or a null quaternion leaves yaw at zero
   assign g_abs = g_ff[33] ? 34'(-g_ff) : 34'(g_ff);
   assign degen = ({g_abs, 1'b0} >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      if (cmd.yaw_init || cmd.tgt_init) begin
         if (ix < 0) begin
            x_ff <= -ix;
            y_ff <= -iy;
            z_ff <= (iy >= 0) ? PI_Q30 : -PI_Q30;
         end else begin
            x_ff <= ix;
            y_ff <= iy;
            z_ff <= '0;
         end
      end else if (cmd.step) begin
         if (!y_ff[XW-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tgt_init) begin
         yaw_ff <= degen ? '0 : z_ff;
      end
   end

   // distance: magnitude times 1/K, two partial products
   logic [MW-1:0]   mag;
   logic [47:0]     plo_ff;
   logic [49:0]     phi;
   logic [67:0]     dsum;
   logic [DW-1:0]   dist_ff;

   assign mag  = x_ff[XW-1:PRESHIFT];
   assign phi  = mag[MW-1:18] * INV_K_Q30;
   assign dsum = {phi, 18'b0} + {20'b0, plo_ff};

   always_ff @(posedge clock) begin
      if (cmd.dist_lo) begin
         plo_ff <= mag[17:0] * INV_K_Q30;
      end
      if (cmd.dist_hi) begin
         dist_ff <= dsum[67:30];
      end
   end

   // heading error, wrapped and rounded to q7.13
   logic signed [ZW:0]   err, errw, erd;
   logic signed [EW-1:0] e13_in, e13_ff;
   logic [EW-1:0]        e13_abs;
   logic                 turn_in, turn_ff;

   assign err = {z_ff[ZW-1], z_ff} - {yaw_ff[ZW-1], yaw_ff};

   always_comb begin
      if (err > PI_EXT) begin
         errw = err - TWO_PI_Q30;
      end else if (err < -PI_EXT) begin
         errw = err + TWO_PI_Q30;
      end else begin
         errw = err;
      end
   end

   assign erd        = (errw + 37'sd65536) >>> 17;
   assign e13_in     = erd[EW-1:0];
   assign e13_abs    = e13_in[EW-1] ? EW'(-e13_in) : EW'(e13_in);
   assign reached_in = (dist_ff < {{(DW - 17){1'b0}}, dist_tol_ff});
   assign turn_in    = (e13_abs > {{(EW - 15){1'b0}}, angle_tol_ff});

   always_ff @(posedge clock) begin
      if (cmd.err) begin
         e13_ff     <= e13_in;
         reached_ff <= reached_in;
         turn_ff    <= !reached_in && turn_in;
      end
   end

   // gain products
   logic [14:0]        gsel;
   logic signed [35:0] aprod, around;
   logic [52:0]        lprod, lround;
   logic signed [22:0] ang_ff;
   logic [36:0]        lin_ff;

   assign gsel   = turn_ff ? turn_gain_ff : head_gain_ff;
   assign aprod  = $signed({1'b0, gsel}) * e13_ff;
   assign around = (aprod + 36'sd4096) >>> 13;
   assign lprod  = drive_gain_ff * dist_ff;
   assign lround = (lprod + 53'd32768) >> 16;

   always_ff @(posedge clock) begin
      if (cmd.gain) begin
         ang_ff <= around[22:0];
         lin_ff <= lround[36:0];
      end
   end

   // saturation and result register
   logic signed [22:0] amax;
   logic [14:0]        lin_sat;
   logic signed [15:0] ang_sat;

   assign amax = $signed({8'b0, max_ang_ff});

   always_comb begin
      if (reached_ff || turn_ff) begin
         lin_sat = '0;
      end else if (lin_ff > {22'b0, max_lin_ff}) begin
         lin_sat = max_lin_ff;
      end else begin
         lin_sat = lin_ff[14:0];
      end

      if (reached_ff) begin
         ang_sat = '0;
      end else if (turn_ff) begin
         if (ang_ff > amax) begin
            ang_sat = amax[15:0];
         end else if (ang_ff < -amax) begin
            ang_sat = 16'(-amax);
         end else begin
            ang_sat = ang_ff[15:0];
         end
      end else if (ang_ff > 23'sd32767) begin
         ang_sat = 16'sh7FFF;
      end else if (ang_ff < -23'sd32768) begin
         ang_sat = 16'sh8000;
      end else begin
         ang_sat = ang_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_linear_speed  <= lin_sat;
         rsp_angular_speed <= ang_sat;
         rsp_goal_reached  <= reached_ff;
      end
   end

endmodule

// ===== src/go_to_goal_steering.sv =====
// top level of the go-to-goal steering block
//
// request channel (req_): one transaction is a goal set (opcode 0) or a
// control tick (opcode 1) carrying position and orientation quaternion
// a goal set stores the goal, arms the block and gives no response
// a tick with no goal armed gives no response and is done at once
// an armed tick gives one response transaction (rsp_): linear speed,
// angular speed and a goal reached flag; reaching the goal disarms
// an armed tick runs eight quaternion products through one multiplier and
// two passes of the shared cordic unit, one iteration a cycle; one tick
// is worked on at a time, and goal sets are taken one a cycle while idle
// the response sits in an output register: a new request is taken while
// the receiver stalls, and the next result waits until the old one leaves
// synchronous reset restores register defaults and disarms the goal
// csr_ writes are taken at each edge with csr_wr_en high; the user is to
// write them only while idle, which the block itself does not enforce
module go_to_goal_steering
   import gtg_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   // configuration writes
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_wdata,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_linear_speed,
   output logic signed [15:0] rsp_angular_speed,
   output logic               rsp_goal_reached
);

   cmd_type    cmd;
   status_type status;

   // sequencer: walks products, two cordic passes, distance, error, gains
   gtg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic, goal and configuration registers, response register
   gtg_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_opcode        (req_opcode),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_quat_x        (req_quat_x),
      .req_quat_y        (req_quat_y),
      .req_quat_z        (req_quat_z),
      .req_quat_w        (req_quat_w),
      .cmd               (cmd),
      .status            (status),
      .rsp_linear_speed  (rsp_linear_speed),
      .rsp_angular_speed (rsp_angular_speed),
      .rsp_goal_reached  (rsp_goal_reached)
   );

endmodule
